// ===== sv/tgr_pkg.sv =====
`timescale 1ns / 1ps

package tgr_pkg;

    // Transfer limits
    localparam int BLOCK_BYTES  = 512;
    localparam int MAX_DATAGRAM = 518;
    localparam int IDX_W        = $clog2(MAX_DATAGRAM + 1);

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;
    localparam int NRES      = 3;

    // Opcodes of interest
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [15:0] OP_OACK  = 16'd6;

    // Header lengths in bytes
    localparam logic [2:0] HDR_NARROW = 3'd4;
    localparam logic [2:0] HDR_WIDE   = 3'd6;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TIMEOUT = 2'd1,
        CMD_START   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ACT_IGNORE = 2'd0,
        ACT_ACCEPT = 2'd1,
        ACT_REACK  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_ACK      = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_FAIL     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        FAIL_NONE      = 3'd0,
        FAIL_FIRST     = 3'd1,
        FAIL_SERVER    = 3'd2,
        FAIL_OPCODE    = 3'd3,
        FAIL_SHORT     = 3'd4,
        FAIL_TIMEOUT   = 3'd5
    } fail_t;

    // One input request as held in the input register
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic       end_of_datagram;
    } item_t;

    // One result
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] ack_num;
        logic        ack_wide;
        fail_t       fail_code;
        logic        last;
    } result_t;

    function automatic result_t make_result(kind_t k, logic [7:0] pb, logic [31:0] blk,
                                            logic wide, fail_t fc);
        result_t r;
        r.kind         = k;
        r.payload_byte = pb;
        r.ack_num      = blk;
        r.ack_wide     = wide;
        r.fail_code    = fc;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/tgr_engine.sv =====
`timescale 1ns / 1ps

module tgr_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 fire,
    input  tgr_pkg::item_t                       item,
    output tgr_pkg::result_t [tgr_pkg::NRES-1:0] res,
    output logic [1:0]                           res_cnt
);

    tgr_pkg::phase_t            phase_reg, phase_next;
    tgr_pkg::action_t           act_reg, act_next;
    logic                       wide_reg, wide_next;
    logic [31:0]                exp_reg, exp_next;
    logic [tgr_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [15:0]                op_reg, op_next;
    logic [31:0]                blk_reg, blk_next;

    // header length for the current block number width
    function automatic logic [2:0] HDR_NARROW_SEL(logic wide);
        return wide ? tgr_pkg::HDR_WIDE : tgr_pkg::HDR_NARROW;
    endfunction

    // Receive step: state update and results for one request
    always_comb begin
        logic [1:0]                n;
        logic [2:0]                hdr;
        logic [tgr_pkg::IDX_W-1:0] len;
        logic                      data_path;
        phase_next = phase_reg;
        act_next   = act_reg;
        wide_next  = wide_reg;
        exp_next   = exp_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        blk_next   = blk_reg;
        res        = '0;
        n          = 2'd0;
        hdr        = HDR_NARROW_SEL(wide_reg);
        len        = '0;
        data_path  = 1'b0;

        unique case (item.command)
            tgr_pkg::CMD_START: begin
                phase_next = tgr_pkg::PH_FIRST;
                exp_next   = 32'd1;
                idx_next   = '0;
                op_next    = '0;
                blk_next   = '0;
                act_next   = tgr_pkg::ACT_IGNORE;
            end
            tgr_pkg::CMD_TIMEOUT: begin
                if (phase_reg != tgr_pkg::PH_IDLE) begin
                    res[n] = tgr_pkg::make_result(tgr_pkg::KIND_FAIL, '0, '0, 1'b0,
                                                  tgr_pkg::FAIL_TIMEOUT);
                    n          = n + 2'd1;
                    phase_next = tgr_pkg::PH_IDLE;
                    idx_next   = '0;
                    blk_next   = '0;
                    act_next   = tgr_pkg::ACT_IGNORE;
                end
            end
            tgr_pkg::CMD_BYTE: begin
                if (phase_reg != tgr_pkg::PH_IDLE) begin
                    // header assembly and payload pass-through
                    if (idx_reg < tgr_pkg::IDX_W'(tgr_pkg::MAX_DATAGRAM)) begin
                        if (idx_reg < tgr_pkg::IDX_W'(2))
                            op_next = {op_reg[7:0], item.rx_byte};
                        if (phase_reg == tgr_pkg::PH_FIRST && idx_reg == tgr_pkg::IDX_W'(1)
                            && op_next == tgr_pkg::OP_DATA)
                            wide_next = 1'b0;
                        hdr = HDR_NARROW_SEL(wide_next);
                        data_path = (phase_reg == tgr_pkg::PH_DATA) ||
                                    (phase_reg == tgr_pkg::PH_FIRST &&
                                     op_next == tgr_pkg::OP_DATA);
                        if (idx_reg >= tgr_pkg::IDX_W'(2) && data_path) begin
                            if (idx_reg < tgr_pkg::IDX_W'(hdr)) begin
                                blk_next = {blk_reg[23:0], item.rx_byte};
                                if (idx_reg == tgr_pkg::IDX_W'(hdr - 3'd1)) begin
                                    if (blk_next == exp_reg)
                                        act_next = tgr_pkg::ACT_ACCEPT;
                                    else if (blk_next < exp_reg)
                                        act_next = tgr_pkg::ACT_REACK;
                                    else
                                        act_next = tgr_pkg::ACT_IGNORE;
                                end
                            end else if (act_reg == tgr_pkg::ACT_ACCEPT) begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_PAYLOAD,
                                                              item.rx_byte, '0, 1'b0,
                                                              tgr_pkg::FAIL_NONE);
                                n = n + 2'd1;
                            end
                        end
                        idx_next = idx_reg + tgr_pkg::IDX_W'(1);
                    end

                    // end of datagram
                    if (item.end_of_datagram) begin
                        len = idx_next;
                        hdr = HDR_NARROW_SEL(wide_next);
                        data_path = 1'b0;
                        if (phase_reg == tgr_pkg::PH_FIRST) begin
                            if (len < tgr_pkg::IDX_W'(4)) begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_FAIL, '0, '0,
                                                              1'b0, tgr_pkg::FAIL_FIRST);
                                n = n + 2'd1;
                                phase_next = tgr_pkg::PH_IDLE;
                            end else if (op_next == tgr_pkg::OP_ERROR) begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_FAIL, '0, '0,
                                                              1'b0, tgr_pkg::FAIL_SERVER);
                                n = n + 2'd1;
                                phase_next = tgr_pkg::PH_IDLE;
                            end else if (op_next == tgr_pkg::OP_OACK) begin
                                wide_next = 1'b1;
                                exp_next  = 32'd1;
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_ACK, '0, '0,
                                                              1'b1, tgr_pkg::FAIL_NONE);
                                n = n + 2'd1;
                                phase_next = tgr_pkg::PH_DATA;
                            end else if (op_next == tgr_pkg::OP_DATA) begin
                                data_path  = 1'b1;
                                phase_next = tgr_pkg::PH_DATA;
                            end else begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_FAIL, '0, '0,
                                                              1'b0, tgr_pkg::FAIL_OPCODE);
                                n = n + 2'd1;
                                phase_next = tgr_pkg::PH_IDLE;
                            end
                        end else begin
                            data_path = 1'b1;
                        end

                        // close a data packet
                        if (data_path) begin
                            if (len < tgr_pkg::IDX_W'(hdr)) begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_FAIL, '0, '0,
                                                              1'b0, tgr_pkg::FAIL_SHORT);
                                n = n + 2'd1;
                                phase_next = tgr_pkg::PH_IDLE;
                            end else if (act_next == tgr_pkg::ACT_ACCEPT) begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_ACK, '0, blk_next,
                                                              wide_next, tgr_pkg::FAIL_NONE);
                                n = n + 2'd1;
                                exp_next = exp_reg + 32'd1;
                                if ({1'b0, len - tgr_pkg::IDX_W'(hdr)} <
                                    (tgr_pkg::IDX_W + 1)'(tgr_pkg::BLOCK_BYTES)) begin
                                    res[n] = tgr_pkg::make_result(tgr_pkg::KIND_COMPLETE, '0,
                                                                  '0, 1'b0,
                                                                  tgr_pkg::FAIL_NONE);
                                    n = n + 2'd1;
                                    phase_next = tgr_pkg::PH_IDLE;
                                end
                            end else if (act_next == tgr_pkg::ACT_REACK) begin
                                res[n] = tgr_pkg::make_result(tgr_pkg::KIND_ACK, '0, blk_next,
                                                              wide_next, tgr_pkg::FAIL_NONE);
                                n = n + 2'd1;
                            end
                        end

                        idx_next = '0;
                        blk_next = '0;
                        act_next = tgr_pkg::ACT_IGNORE;
                    end
                end
            end
            default: begin
            end
        endcase

        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;
        res_cnt = n;
    end

    // Receiver state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tgr_pkg::PH_IDLE;
            act_reg   <= tgr_pkg::ACT_IGNORE;
            wide_reg  <= 1'b0;
            exp_reg   <= 32'd1;
            idx_reg   <= '0;
            op_reg    <= '0;
            blk_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            wide_reg  <= wide_next;
            exp_reg   <= exp_next;
            idx_reg   <= idx_next;
            op_reg    <= op_next;
            blk_reg   <= blk_next;
        end
    end

endmodule

// ===== sv/tftp_get_receiver.sv =====
`timescale 1ns / 1ps
// Path: a request passes through the input register and then the result buffer before its first result is on m_.
// Throughput: one request per cycle while the result buffer is free; the results of a request (at most
// three) hold the result buffer until the single result port has taken each of them.
// Reset: aresetn is synchronous, active low; it empties the input register and the
// result buffer and returns the receiver to idle with expected block one.

module tftp_get_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tgr_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte
    input  logic [tgr_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] command
    input  logic                          s_tlast,  // end_of_datagram
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] payload_byte, [39:8] ack_num, [40] ack_wide, [43:41] fail_code, [47:44] zero
    output logic [tgr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [tgr_pkg::M_TUSER_W-1:0] m_tuser,  // [1:0] kind
    output logic                          m_tlast   // last
);

    tgr_pkg::item_t                       item_reg;
    logic                                 item_valid_reg;
    tgr_pkg::result_t [tgr_pkg::NRES-1:0] slot_reg;
    logic [1:0]                           cnt_reg;
    tgr_pkg::result_t [tgr_pkg::NRES-1:0] res;
    logic [1:0]                           res_cnt;
    logic                                 load;
    logic                                 drain;

    // Process the held request once the buffer is empty or emptying
    assign drain    = m_tvalid && m_tready;
    assign load     = item_valid_reg &&
                      (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_tready));
    assign s_tready = !item_valid_reg || load;

    tgr_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (load),
        .item    (item_reg),
        .res     (res),
        .res_cnt (res_cnt)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            item_valid_reg <= 1'b1;
        end else if (load) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command         <= s_tuser;
            item_reg.rx_byte         <= s_tdata;
            item_reg.end_of_datagram <= s_tlast;
        end
    end

    // Result buffer: head slot drives the output, shifts down on each take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res_cnt;
        end else if (drain) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= res;
        end else if (drain) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // Output packing
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {4'b0000, slot_reg[0].fail_code, slot_reg[0].ack_wide,
                       slot_reg[0].ack_num, slot_reg[0].payload_byte};
    assign m_tuser  = slot_reg[0].kind;
    assign m_tlast  = slot_reg[0].last;

endmodule
